// ===== rtl/cfp_pkg.sv =====
// Shared types and constants for the camera frame parser.
`timescale 1ns / 1ps
package cfp_pkg;

   localparam int unsigned PAYLOAD_LEN   = 12;
   localparam int unsigned PAYLOAD_FIRST = 2;
   localparam logic [3:0]  POS_LAST      = 4'd14;
   localparam logic [3:0]  POS_FIRST     = 4'd2;
   localparam logic [3:0]  POS_HUNT_IDLE = 4'd0;
   localparam logic [3:0]  POS_HUNT_PREV = 4'd1;

   localparam logic [1:0]  CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0]  CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0]  CSR_ERROR_MARKER  = 2'd2;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] error_marker;
   } cfg_type;

   typedef logic [PAYLOAD_LEN-1:0][7:0] payload_type;

   typedef struct packed {
      logic        done;     // final byte of a frame accepted this cycle
      logic        good;     // checksum matched
      payload_type payload;  // frame positions 2 to 13
   } frame_end_type;

endpackage

// ===== rtl/cfp_frame_track.sv =====
// Header hunt, position counter, running checksum and payload capture.
`timescale 1ns / 1ps
module cfp_frame_track (
   input  logic                   clock,
   input  logic                   reset,
   input  cfp_pkg::cfg_type       cfg,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output logic                   at_last,
   output cfp_pkg::frame_end_type frame_end
);
   import cfp_pkg::*;

   logic        synced_ff, synced_in;
   logic [7:0]  prev_ff, prev_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   payload_type payload_ff;
   logic [3:0]  slot;

   assign at_last = synced_ff && (pos_ff == POS_LAST);
   assign slot    = pos_ff - POS_FIRST;

   always_comb begin
      synced_in = synced_ff;
      prev_in   = prev_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      if (accept) begin
         if (!synced_ff) begin
            if (pos_ff == POS_HUNT_IDLE) begin
               prev_in = rx_byte;
               pos_in  = POS_HUNT_PREV;
            end else if (prev_ff == cfg.header_first && rx_byte == cfg.header_second) begin
               synced_in = 1'b1;
               pos_in    = POS_FIRST;
               sum_in    = cfg.header_first + cfg.header_second;
            end else begin
               prev_in = rx_byte;
            end
         end else if (pos_ff != POS_LAST) begin
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 4'd1;
         end else begin
            // frame complete: back to hunting
            synced_in = 1'b0;
            prev_in   = 8'd0;
            pos_in    = POS_HUNT_IDLE;
            sum_in    = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff <= 1'b0;
         prev_ff   <= 8'd0;
         pos_ff    <= POS_HUNT_IDLE;
         sum_ff    <= 8'd0;
      end else begin
         synced_ff <= synced_in;
         prev_ff   <= prev_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
      end
   end

   // payload bytes land at their frame slot; no reset needed
   always_ff @(posedge clock) begin
      if (accept && synced_ff && pos_ff != POS_LAST) begin
         payload_ff[slot] <= rx_byte;
      end
   end

   assign frame_end.done    = accept && at_last;
   assign frame_end.good    = (sum_ff == rx_byte);
   assign frame_end.payload = payload_ff;

endmodule

// ===== rtl/cfp_record_latch.sv =====
// Target record latches and the result register.
`timescale 1ns / 1ps
module cfp_record_latch (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             error_marker,
   input  cfp_pkg::frame_end_type frame_end,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   frame_good,
   output logic                   checksum_bad,
   output logic                   lower_updated,
   output logic [2:0][15:0]       lower_rec,
   output logic                   upper_updated,
   output logic [2:0][15:0]       upper_rec
);
   import cfp_pkg::*;

   logic             valid_ff, valid_in;
   logic             good_ff, lo_upd_ff, up_upd_ff;
   logic             lo_ok, up_ok;
   logic [2:0][15:0] lower_ff, upper_ff, lo_new, up_new;
   payload_type      p;

   assign p     = frame_end.payload;
   assign lo_ok = frame_end.good && p[0] != error_marker && p[1] != error_marker;
   assign up_ok = frame_end.good && p[6] != error_marker && p[7] != error_marker;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_new[k] = {p[2*k], p[2*k+1]};
         up_new[k] = {p[6+2*k], p[7+2*k]};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (frame_end.done) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         good_ff   <= 1'b0;
         lo_upd_ff <= 1'b0;
         up_upd_ff <= 1'b0;
         lower_ff  <= '0;
         upper_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (frame_end.done) begin
            good_ff   <= frame_end.good;
            lo_upd_ff <= lo_ok;
            up_upd_ff <= up_ok;
            if (lo_ok) begin
               lower_ff <= lo_new;
            end
            if (up_ok) begin
               upper_ff <= up_new;
            end
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign frame_good    = good_ff;
   assign checksum_bad  = !good_ff;
   assign lower_updated = lo_upd_ff;
   assign upper_updated = up_upd_ff;
   assign lower_rec     = lower_ff;
   assign upper_rec     = upper_ff;

endmodule

// ===== rtl/camera_frame_parser_core.sv =====
// Top level of the camera frame parser: config registers and submodule wiring.
//
// Usage: feed received serial bytes on the req_ channel, one word per accepted
// handshake. The block hunts for the two-byte header set by the csr_ port,
// collects frame positions 2 to 14, checks the 8-bit additive checksum and
// emits one rsp_ word per completed frame: good frame with the latched lower
// and upper target records, or a checksum error with the records unchanged.
// Bytes outside a frame give no result.
// Throughput: one byte per cycle while req_ready is high. Latency: the result
// word is valid the cycle after the final frame byte (position 14) is accepted.
// req_ready drops only while the next byte would close a frame and the result
// register still holds a word the receiver has not taken; all other bytes
// are taken even while the receiver stalls.
// Reset clears the header and marker registers, hunt state and both records.
// Write csr_ registers only while no frame is in progress.
`timescale 1ns / 1ps
module camera_frame_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_good,
   output logic               rsp_checksum_bad,
   output logic               rsp_lower_updated,
   output logic signed [15:0] rsp_lower_angle,
   output logic signed [15:0] rsp_lower_x,
   output logic signed [15:0] rsp_lower_y,
   output logic               rsp_upper_updated,
   output logic signed [15:0] rsp_upper_angle,
   output logic signed [15:0] rsp_upper_x,
   output logic signed [15:0] rsp_upper_y
);
   import cfp_pkg::*;

   cfg_type          cfg_ff;
   frame_end_type    frame_end;
   logic             at_last;
   logic             accept;
   logic [2:0][15:0] lower_rec, upper_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_FIRST:  cfg_ff.header_first  <= csr_wdata;
            CSR_HEADER_SECOND: cfg_ff.header_second <= csr_wdata;
            CSR_ERROR_MARKER:  cfg_ff.error_marker  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold only the frame-closing byte while a result is stuck
   assign req_ready = !at_last || !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   cfp_frame_track u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .at_last   (at_last),
      .frame_end (frame_end)
   );

   cfp_record_latch u_records (
      .clock         (clock),
      .reset         (reset),
      .error_marker  (cfg_ff.error_marker),
      .frame_end     (frame_end),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .frame_good    (rsp_frame_good),
      .checksum_bad  (rsp_checksum_bad),
      .lower_updated (rsp_lower_updated),
      .lower_rec     (lower_rec),
      .upper_updated (rsp_upper_updated),
      .upper_rec     (upper_rec)
   );

   assign rsp_lower_angle = lower_rec[0];
   assign rsp_lower_x     = lower_rec[1];
   assign rsp_lower_y     = lower_rec[2];
   assign rsp_upper_angle = upper_rec[0];
   assign rsp_upper_x     = upper_rec[1];
   assign rsp_upper_y     = upper_rec[2];

endmodule

// ===== rtl/cfp_checker.sv =====
// Port-level assertions for the camera frame parser, bound to the top level.
`timescale 1ns / 1ps
module cfp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_frame_good,
   input logic rsp_checksum_bad,
   input logic rsp_lower_updated,
   input logic rsp_upper_updated
);

   // a stalled result word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_good != rsp_checksum_bad)
      else $error("good and bad flags agree");

   a_bad_no_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_bad |-> !rsp_lower_updated && !rsp_upper_updated)
      else $error("record updated on checksum error");

   // a fresh result needs an accepted byte the cycle before
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready))
      else $error("result word without an accepted byte");

endmodule

bind camera_frame_parser_core cfp_checker u_cfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_frame_good    (rsp_frame_good),
   .rsp_checksum_bad  (rsp_checksum_bad),
   .rsp_lower_updated (rsp_lower_updated),
   .rsp_upper_updated (rsp_upper_updated)
);
